### hw/rtl/sv39ptw_pkg.sv
// Shared constants and codes for the Sv39 page-table walker.
// Holds store geometry, field widths, operation and status codes.
// No dependencies.
package sv39ptw_pkg;

   // Store geometry
   localparam int TABLE_PAGES       = 8;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int STORE_WORDS       = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int SLOT_W            = $clog2(TABLE_PAGES);
   localparam int INDEX_W           = $clog2(ENTRIES_PER_TABLE);
   localparam int STORE_AW          = $clog2(STORE_WORDS);

   // Field widths
   localparam int PPN_W         = 44;
   localparam int VA_W          = 64;
   localparam int PA_W          = 56;
   localparam int WORD_W        = 64;
   localparam int WADDR_W       = 12;
   localparam int STATUS_W      = 3;
   localparam int PAGE_OFFSET_W = 12;
   localparam int LEVELS        = 3;
   localparam int VPN_W         = LEVELS * INDEX_W;
   localparam int VA_LIMIT_BITS = 38;

   // PTE layout
   localparam int PTE_VALID_BIT = 0;
   localparam int PTE_USER_BIT  = 4;
   localparam int PTE_PPN_LSB   = 10;

   typedef enum logic [0:0] {
      OP_WRITE     = 1'b0,
      OP_TRANSLATE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_VA_RANGE     = 3'd1,
      STATUS_DIR_INVALID  = 3'd2,
      STATUS_LEAF_INVALID = 3'd3,
      STATUS_NOT_USER     = 3'd4
   } status_type;

endpackage

### hw/rtl/sv39_page_table_walker.sv
// Sv39 page-table walker: sequencer, local PTE store and result register.
// Depends on sv39ptw_pkg.
//
// Each item is a table-word write or a translation. A write goes from the
// transfer straight to the done state; a translation reads one entry for
// each of the three levels from the single-port table store, top level
// first, and goes to the done state early when the level-1 entry is invalid,
// when the level-2 entry is invalid, or when the address is at or above 2^38.
// In the done state an item also waits while the output register still
// holds a result under rsp_stall. The block takes one item at a time:
// req_stall stays high until the item's result is in the output register,
// and a result waits there while rsp_stall is high. After reset the store
// is cleared one word a cycle, so no item is taken until all 4096 words are
// cleared; root page writes on the csr_ port are taken at any time.
module sv39_page_table_walker (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sv39ptw_pkg::PPN_W-1:0]        csr_root_table_page,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [sv39ptw_pkg::WADDR_W-1:0]      req_word_addr,
   input  logic [sv39ptw_pkg::WORD_W-1:0]       req_word_data,
   input  logic [sv39ptw_pkg::VA_W-1:0]         req_virt_addr,
   // Response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sv39ptw_pkg::PA_W-1:0]         rsp_phys_addr,
   output logic [sv39ptw_pkg::STATUS_W-1:0]     rsp_status
);
   import sv39ptw_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DONE
   } state_type;

   localparam logic [STORE_AW-1:0] CLR_LAST   = STORE_AW'(STORE_WORDS - 1);
   localparam logic [STORE_AW:0]   STORE_END  = (STORE_AW + 1)'(STORE_WORDS);
   localparam logic [1:0]          LEVEL_TOP  = 2'(LEVELS - 1);
   localparam logic [1:0]          LEVEL_LEAF = 2'd0;

   // Pick the 9-bit table index for a level out of the VPN
   function automatic logic [INDEX_W-1:0] vpn_index(input logic [VPN_W-1:0] vpn,
                                                   input logic [1:0] level);
      logic [INDEX_W-1:0] idx;
      case (level)
         2'd2:    idx = vpn[2*INDEX_W +: INDEX_W];
         2'd1:    idx = vpn[INDEX_W +: INDEX_W];
         default: idx = vpn[0 +: INDEX_W];
      endcase
      return idx;
   endfunction

   state_type                 state_ff;
   logic [STORE_AW-1:0]       clr_ff;
   logic [1:0]                level_ff;
   logic [VPN_W-1:0]          vpn_ff;
   logic [PPN_W-1:0]          root_ff;
   logic [PA_W-1:0]           res_pa_ff;
   status_type                res_status_ff;
   logic                      rsp_valid_ff;
   logic [PA_W-1:0]           rsp_pa_ff;
   status_type                rsp_status_ff;

   logic [WORD_W-1:0]         table_mem [STORE_WORDS];
   logic [WORD_W-1:0]         mem_rd_ff;

   logic                      req_fire;
   logic                      out_free;
   logic                      va_too_large;
   logic                      waddr_in_range;
   logic                      entry_valid;
   logic                      entry_user;
   logic [PPN_W-1:0]          entry_ppn;
   logic                      mem_we;
   logic                      mem_re;
   logic [STORE_AW-1:0]       mem_addr;
   logic [WORD_W-1:0]         mem_wdata;

   // Handshakes
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phys_addr = rsp_pa_ff;
   assign rsp_status    = rsp_status_ff;

   // Request decode and fetched entry fields
   assign va_too_large   = |req_virt_addr[VA_W-1:VA_LIMIT_BITS];
   assign waddr_in_range = ({1'b0, req_word_addr[STORE_AW-1:0]} < STORE_END)
                           && (WADDR_W'(req_word_addr[STORE_AW-1:0]) == req_word_addr);
   assign entry_valid    = mem_rd_ff[PTE_VALID_BIT];
   assign entry_user     = mem_rd_ff[PTE_USER_BIT];
   assign entry_ppn      = mem_rd_ff[PTE_PPN_LSB +: PPN_W];

   // Store port: clearing pass, table writes, level reads
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = clr_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_op) == OP_WRITE) begin
                  mem_we    = waddr_in_range;
                  mem_addr  = req_word_addr[STORE_AW-1:0];
                  mem_wdata = req_word_data;
               end else if (!va_too_large) begin
                  mem_re   = 1'b1;
                  mem_addr = {root_ff[SLOT_W-1:0],
                              vpn_index(req_virt_addr[PAGE_OFFSET_W +: VPN_W], LEVEL_TOP)};
               end
            end
         end
         ST_LOOKUP: begin
            if (level_ff != LEVEL_LEAF && entry_valid) begin
               mem_re   = 1'b1;
               mem_addr = {entry_ppn[SLOT_W-1:0], vpn_index(vpn_ff, level_ff - 2'd1)};
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Table store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= table_mem[mem_addr];
      end
   end

   // Sequencer, root register and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            root_ff <= csr_root_table_page;
         end
         // the done state refills the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  vpn_ff    <= req_virt_addr[PAGE_OFFSET_W +: VPN_W];
                  level_ff  <= LEVEL_TOP;
                  res_pa_ff <= '0;
                  if (op_type'(req_op) == OP_TRANSLATE) begin
                     if (va_too_large) begin
                        res_status_ff <= STATUS_VA_RANGE;
                        state_ff      <= ST_DONE;
                     end else begin
                        res_status_ff <= STATUS_OK;
                        state_ff      <= ST_LOOKUP;
                     end
                  end else begin
                     res_status_ff <= STATUS_OK;
                     state_ff      <= ST_DONE;
                  end
               end
            end
            ST_LOOKUP: begin
               if (level_ff != LEVEL_LEAF) begin
                  // directory level: only the valid bit matters
                  if (!entry_valid) begin
                     res_status_ff <= STATUS_DIR_INVALID;
                     state_ff      <= ST_DONE;
                  end else begin
                     level_ff <= level_ff - 2'd1;
                  end
               end else begin
                  state_ff <= ST_DONE;
                  if (!entry_valid) begin
                     res_status_ff <= STATUS_LEAF_INVALID;
                  end else if (!entry_user) begin
                     res_status_ff <= STATUS_NOT_USER;
                  end else begin
                     res_pa_ff <= {entry_ppn, PAGE_OFFSET_W'(0)};
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_pa_ff     <= res_pa_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   // Checks
   a_store_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("table store written outside clear or idle");

   a_store_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("table store read and written in one cycle");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> (level_ff != 2'd3))
      else $error("walk level out of range");

   a_fault_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_pa_ff == '0))
      else $error("faulting response carries an address");

   a_page_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pa_ff[PAGE_OFFSET_W-1:0] == '0))
      else $error("response address not page aligned");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff))
      else $error("reset did not start the clearing pass");

endmodule
